FILE: design/pcrc_pkg.sv
package pcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [1:0]  SEEN_MAX = 2'd2;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       good;
  } result_t;

  // Results caused by one request, res[0] goes out first.
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } group_t;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/pcrc_core.sv
module pcrc_core import pcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       mode,
  input  logic       grp_ready,
  output logic       grp_valid,
  output group_t     grp
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic [15:0] crc_running;
  logic [15:0] crc_one_back;
  logic [7:0]  previous_byte;
  logic [1:0]  bytes_seen;
  logic [15:0] crc_next;
  logic        take;
  logic        good;

  assign take      = hold_valid && grp_ready;
  assign in_ready  = !hold_valid || grp_ready;
  assign grp_valid = hold_valid;
  assign crc_next  = crc_byte_update(crc_running, hold_byte);

  // trailer = previous byte (low), this byte (high), over CRC before both
  assign good = (bytes_seen != 2'd0) &&
                (previous_byte == crc_one_back[7:0]) &&
                (hold_byte == crc_one_back[15:8]);

  always_comb begin
    grp = '0;
    grp.res[0].data = hold_byte;
    if (!hold_last) begin
      grp.cnt = 2'd1;
    end else if (mode) begin
      grp.cnt         = 2'd3;
      grp.res[1].data = crc_next[7:0];
      grp.res[2].data = crc_next[15:8];
      grp.res[2].last = 1'b1;
    end else begin
      grp.cnt         = 2'd1;
      grp.res[0].last = 1'b1;
      grp.res[0].done = 1'b1;
      grp.res[0].good = good;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running   <= CRC_INIT;
      crc_one_back  <= CRC_INIT;
      previous_byte <= 8'h00;
      bytes_seen    <= 2'd0;
    end else if (take) begin
      if (hold_last) begin
        crc_running   <= CRC_INIT;
        crc_one_back  <= CRC_INIT;
        previous_byte <= 8'h00;
        bytes_seen    <= 2'd0;
      end else begin
        crc_running   <= crc_next;
        crc_one_back  <= crc_running;
        previous_byte <= hold_byte;
        if (bytes_seen != SEEN_MAX) begin
          bytes_seen <= bytes_seen + 2'd1;
        end
      end
    end
  end

endmodule

FILE: design/pcrc_outbuf.sv
module pcrc_outbuf import pcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       grp_valid,
  output logic       grp_ready,
  input  group_t     grp,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       check_done,
  output logic       crc_good
);

  logic [1:0]    cnt;
  result_t [2:0] q;
  logic          pop;
  logic          load;

  assign out_valid  = (cnt != 2'd0);
  assign pop        = out_valid && out_ready;
  assign grp_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && pop);
  assign load       = grp_valid && grp_ready;
  assign out_byte   = q[0].data;
  assign out_last   = q[0].last;
  assign check_done = q[0].done;
  assign crc_good   = q[0].good;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
    if (load) begin
      q <= grp.res;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

FILE: design/packet_crc16_fill_and_check_unit.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | in_byte, in_last
// output    | out_valid / out_ready| out_byte, out_last, check_done, crc_good
// config    | cfg_we (no wait)     | cfg_wdata -> mode (reset 1 = fill)
//
// One request per cycle sustained while out_ready stays high and no fill
// trailer drains. A request is held in the input register, where the
// byte-wide CRC update runs, then moves into the result buffer, which
// offers the first result. A last byte in fill mode yields three results
// and holds off the input while the CRC trailer drains; everything else is
// one result. Stalls on out_ready back up through the buffer into in_ready.
// Synchronous reset clears the CRC state, the buffer and sets mode to fill.
module packet_crc16_fill_and_check_unit import pcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       check_done,
  output logic       crc_good
);

  logic   mode;       // 1: append trailer, 0: check trailer
  logic   grp_valid;
  logic   grp_ready;
  group_t grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // input register, CRC state and result assembly
  pcrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .mode      (mode),
    .grp_ready (grp_ready),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  // up to three results per request, drained one per cycle while out_ready is high
  pcrc_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .check_done (check_done),
    .crc_good   (crc_good)
  );

  // a verdict is only ever given with check_done
  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_good |-> check_done)
    else $error("crc_good without check_done");

  // a verdict always closes the packet
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_done |-> out_last)
    else $error("check verdict not on last result");

  // a trailer group starts with the echoed payload byte, not the end marker
  a_fill_group_order: assert property (@(posedge clk) disable iff (rst)
    grp_valid && grp_ready && (grp.cnt == 2'd3) |=> out_valid && !out_last)
    else $error("fill trailer group misordered");

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcrc_pkg::*;

  // Mode register values.
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_FILL  = 1'b1;

  // Directed plan: a row either sends one request or rewrites the mode.
  typedef enum logic {ROW_SEND, ROW_MODE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] data;       // request byte, or new mode in bit 0
    logic       last;
    logic       hand;       // first result typed in below
    logic [2:0] flags;      // typed {out_last, check_done, crc_good}
  } plan_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       check_done;
  logic       crc_good;

  // Typed expectation travels with the request, same timing as the payload.
  logic       hand_on    = 1'b0;
  logic [2:0] hand_flags = 3'b000;

  packet_crc16_fill_and_check_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .check_done (check_done),
    .crc_good   (crc_good)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #300000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block: CRC history, byte history and the mode register.
  // ---------------------------------------------------------------------------
  logic        mode_now;
  logic [15:0] crc_now, crc_back1, crc_back2;
  logic [7:0]  prev_b;
  logic [1:0]  seen;

  result_t expected_q[$];
  result_t want;
  int      fail_count = 0;

  // Reflected CRC-16, one message bit at a time against the register LSB.
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic packet_restart();
    crc_now   = CRC_INIT;
    crc_back1 = CRC_INIT;
    crc_back2 = CRC_INIT;
    prev_b    = 8'h00;
    seen      = 2'd0;
  endtask

  // One accepted request: advance the mirror and queue what must come out.
  task automatic take_request(input logic [7:0] b, input logic l,
                              input logic hand, input logic [2:0] flags);
    result_t     r;
    logic        had_one;
    logic [7:0]  p;
    logic [15:0] c;
    p       = prev_b;
    had_one = (seen != 2'd0);
    crc_back2 = crc_back1;
    crc_back1 = crc_now;
    crc_now   = crc16_step(crc_now, b);
    prev_b    = b;
    if (seen < SEEN_MAX) begin
      seen = seen + 2'd1;
    end
    r.data = b;
    r.last = 1'b0;
    r.done = 1'b0;
    r.good = 1'b0;
    if (l && mode_now == MODE_CHECK) begin
      // trailer = two newest bytes, low first, vs CRC of everything before
      c      = crc_back2;
      r.last = 1'b1;
      r.done = 1'b1;
      r.good = had_one && p == c[7:0] && b == c[15:8];
    end
    if (hand) begin
      {r.last, r.done, r.good} = flags;
    end
    expected_q.push_back(r);
    if (l && mode_now == MODE_FILL) begin
      c = crc_now;
      r.data = c[7:0];
      r.last = 1'b0;
      r.done = 1'b0;
      r.good = 1'b0;
      expected_q.push_back(r);
      r.data = c[15:8];
      r.last = 1'b1;
      expected_q.push_back(r);
    end
    if (l) begin
      packet_restart();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_now = MODE_FILL;
      packet_restart();
    end else begin
      if (cfg_we) begin
        mode_now = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        take_request(in_byte, in_last, hand_on, hand_flags);
      end
    end
  end

  task automatic log_fail(input string what, input result_t w);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: got %02h/%b/%b/%b want %02h/%b/%b/%b", $time, what,
               out_byte, out_last, check_done, crc_good, w.data, w.last, w.done, w.good);
    end
  endtask

  // Output side: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        log_fail("result with nothing pending", '0);
      end else begin
        want = expected_q.pop_front();
        if (out_byte !== want.data || out_last !== want.last ||
            check_done !== want.done || crc_good !== want.good) begin
          log_fail("mismatch", want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: segments of steady, random, periodic or heavy stalling, plus
  // one long hold-off requested by the stimulus to back the block up.
  // ---------------------------------------------------------------------------
  bit hold_trigger = 1'b0;

  initial begin
    int seg_kind;
    int seg_left;
    int hold_left;
    seg_kind  = 0;
    seg_left  = 0;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left    = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (seg_kind)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 99) >= 30);
          2: out_ready <= (seg_left % 3 != 0);
          default: out_ready <= ($urandom_range(0, 99) >= 75);
        endcase
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int offered    = 0;

  // Offer one request and hold it until taken; bursts with random gaps.
  task automatic offer(input logic [7:0] b, input logic l,
                       input logic hand, input logic [2:0] flags);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 14);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_last    <= l;
    hand_on    <= hand;
    hand_flags <= flags;
    do @(posedge clk); while (!in_ready);
    offered++;
  endtask

  // Mode is only rewritten once everything in flight has come out.
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_packet(input logic [7:0] body[$]);
    foreach (body[i]) begin
      offer(body[i], i == body.size() - 1, 1'b0, 3'b000);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    plan_row_t   plan [22];
    logic [7:0]  body[$];
    logic [15:0] c;
    logic        pick;
    int          base;
    int          kind;
    int          len;
    int          idx;
    bit          hold_used;

    // Directed part. CRC-16/MODBUS of a lone 0x00 is 0x40BF, of nothing 0xFFFF.
    plan = '{
      '{ROW_SEND, 8'h00, 1'b1, 1'b1, 3'b000},  // fill, one-byte packet
      '{ROW_SEND, 8'hFF, 1'b0, 1'b1, 3'b000},
      '{ROW_SEND, 8'hA5, 1'b1, 1'b1, 3'b000},
      '{ROW_MODE, {7'd0, MODE_CHECK}, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'h37, 1'b1, 1'b1, 3'b110},  // check, too short: bad
      '{ROW_SEND, 8'hFF, 1'b0, 1'b1, 3'b000},
      '{ROW_SEND, 8'hFF, 1'b1, 1'b1, 3'b111},  // trailer only, matches init
      '{ROW_SEND, 8'h00, 1'b0, 1'b1, 3'b000},
      '{ROW_SEND, 8'hBF, 1'b0, 1'b1, 3'b000},
      '{ROW_SEND, 8'h40, 1'b1, 1'b1, 3'b111},  // good trailer
      '{ROW_SEND, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'hBF, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'h41, 1'b1, 1'b1, 3'b110},  // high byte off
      '{ROW_SEND, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'hBE, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'h40, 1'b1, 1'b1, 3'b110},  // low byte off
      '{ROW_SEND, 8'h12, 1'b0, 1'b1, 3'b000},
      '{ROW_MODE, {7'd0, MODE_FILL}, 1'b0, 1'b0, 3'b000},  // switch mid-packet
      '{ROW_SEND, 8'h34, 1'b1, 1'b0, 3'b000},
      '{ROW_SEND, 8'h56, 1'b0, 1'b0, 3'b000},
      '{ROW_MODE, {7'd0, MODE_CHECK}, 1'b0, 1'b0, 3'b000},
      '{ROW_SEND, 8'h80, 1'b1, 1'b1, 3'b110}
    };
    hold_used = 1'b0;

    while (rst) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_MODE) begin
        set_mode(plan[i].data[0]);
      end else begin
        offer(plan[i].data, plan[i].last, plan[i].hand, plan[i].flags);
      end
    end

    // Random part: phases of one mode, mostly well-formed packets.
    base = offered;
    while (offered - base < 200) begin
      pick = ($urandom_range(0, 1) == 1) ? MODE_FILL : MODE_CHECK;
      set_mode(pick);
      repeat ($urandom_range(3, 6)) begin
        kind = $urandom_range(0, 99);
        body.delete();
        if (kind >= 85) begin
          // noise: random bytes, random packet ends, always closed at the end
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            offer(rand_byte(), k == len - 1 || $urandom_range(0, 3) == 0,
                  1'b0, 3'b000);
          end
        end else if (pick == MODE_FILL) begin
          len = (kind < 10) ? 1 : $urandom_range(2, 8);
          repeat (len) body.push_back(rand_byte());
          send_packet(body);
        end else begin
          len = $urandom_range(0, 6);
          c   = CRC_INIT;
          repeat (len) begin
            body.push_back(rand_byte());
            c = crc16_step(c, body[body.size() - 1]);
          end
          body.push_back(c[7:0]);
          body.push_back(c[15:8]);
          if (kind >= 70) begin
            // corrupt one bit of the trailer
            idx       = body.size() - 1 - $urandom_range(0, 1);
            body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
          end
          send_packet(body);
        end
        if (!hold_used && offered - base >= 60) begin
          hold_trigger = 1'b1;
          hold_used    = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
